// ----- rtl/crr_pkg.sv -----
// shared constants, types and lookup functions of the controller report responder
`timescale 1ns / 1ps

package crr_pkg;

  // flash geometry and read clamp
  localparam int FLASH_BYTES    = 524288;
  localparam int FLASH_AW       = $clog2(FLASH_BYTES);
  localparam int MAX_READ_CHUNK = 29;

  // reply layout: flash data area runs from byte 20 to byte 48
  localparam int REPLY_LEN  = 49;
  localparam int DATA_FIRST = 20;
  localparam int DATA_DEPTH = REPLY_LEN - DATA_FIRST;
  localparam int DATA_AW    = $clog2(DATA_DEPTH);
  localparam int BODY_DEPTH = 5;

  // configuration register indexes
  localparam logic [1:0] CFG_DEVICE_KIND   = 2'd0;
  localparam logic [1:0] CFG_BATTERY_LEVEL = 2'd1;
  localparam logic [1:0] CFG_DEVICE_NUMBER = 2'd2;

  // subcommand codes
  localparam logic [7:0] SUB_DEV_INFO = 8'h02;
  localparam logic [7:0] SUB_SET_MODE = 8'h03;
  localparam logic [7:0] SUB_FLASH_RD = 8'h10;
  localparam logic [7:0] SUB_FLASH_WR = 8'h11;
  localparam logic [7:0] SUB_MODE_QRY = 8'h43;
  localparam logic [7:0] SUB_BATTERY  = 8'h50;

  // ack codes
  localparam logic [7:0] ACK_PLAIN  = 8'h80;
  localparam logic [7:0] ACK_DEV    = 8'h82;
  localparam logic [7:0] ACK_FLASH  = 8'h90;
  localparam logic [7:0] ACK_QUERY  = 8'hC0;
  localparam logic [7:0] ACK_BATT   = 8'hD0;

  // report ids and fixed values
  localparam logic [7:0] HDR_REPLY      = 8'h21;
  localparam logic [7:0] LEAD_OUT_REPORT = 8'h01;
  localparam logic [7:0] QRY_MATCH      = 8'h10;

  // command group from controller to datapath
  typedef struct packed {
    logic clear_step;
    logic wr_byte;
    logic finish;
    logic copy_step;
    logic rd_start;
    logic rd_next;
  } crr_cmd_t;

  // status group from datapath to controller
  typedef struct packed {
    logic clear_done;
    logic copy_needed;
    logic copy_done;
    logic stream_final;
  } crr_status_t;

  // battery percent to level code
  function automatic logic [3:0] level_nibble(logic [6:0] lvl);
    logic [3:0] r;
    if (lvl <= 7'd5) r = 4'd0;
    else if (lvl <= 7'd25) r = 4'd2;
    else if (lvl <= 7'd50) r = 4'd4;
    else if (lvl <= 7'd75) r = 4'd6;
    else r = 4'd8;
    return r;
  endfunction

  // battery percent to voltage code
  function automatic logic [15:0] level_volts(logic [6:0] lvl);
    logic [15:0] r;
    if (lvl <= 7'd5) r = 16'h0550;
    else if (lvl <= 7'd25) r = 16'h05B0;
    else if (lvl <= 7'd50) r = 16'h0600;
    else if (lvl <= 7'd75) r = 16'h0630;
    else r = 16'h0660;
    return r;
  endfunction

  // factory flash image, byte by address
  function automatic logic [7:0] factory_byte(logic [23:0] addr);
    logic [15:0] a;
    logic [7:0]  b;
    a = addr[15:0];
    b = 8'hFF;
    if (addr[23:16] == 8'd0) begin
      // zero-filled regions
      if ((a >= 16'h6000 && a <= 16'h600F) || (a >= 16'h6020 && a <= 16'h6037) ||
          (a >= 16'h6080 && a <= 16'h60A9)) begin
        b = 8'h00;
      end
      // serial text
      if (a >= 16'h6004 && a <= 16'h600E) b = 8'h30;
      case (a)
        16'h0000: b = 8'h01;
        16'h0001: b = 8'h08;
        16'h0002: b = 8'h00;
        16'h0003: b = 8'hF0;
        16'h0004: b = 8'h00;
        16'h0005: b = 8'h00;
        16'h0006: b = 8'h62;
        16'h0007: b = 8'h08;
        16'h0008: b = 8'hC0;
        16'h0009: b = 8'h5D;
        16'h000A: b = 8'h89;
        16'h000B: b = 8'hFD;
        16'h000C: b = 8'h04;
        16'h000D: b = 8'h00;
        16'h0012: b = 8'h40;
        16'h0013: b = 8'h06;
        16'h0015: b = 8'h01;
        16'h0016: b = 8'h10;
        16'h0017: b = 8'h00;
        16'h0018: b = 8'h00;
        16'h0019: b = 8'h00;
        16'h001A: b = 8'h02;
        16'h6001: b = 8'h53;
        16'h6002: b = 8'h49;
        16'h6003: b = 8'h4D;
        16'h600F: b = 8'h31;
        16'h6012: b = 8'h01;
        16'h6027: b = 8'h40;
        16'h6029: b = 8'h40;
        16'h602B: b = 8'h40;
        16'h6032: b = 8'h3B;
        16'h6033: b = 8'h34;
        16'h6034: b = 8'h3B;
        16'h6035: b = 8'h34;
        16'h6036: b = 8'h3B;
        16'h6037: b = 8'h34;
        // stick calibration
        16'h603D: b = 8'h00;
        16'h603E: b = 8'h06;
        16'h603F: b = 8'h60;
        16'h6040: b = 8'h00;
        16'h6041: b = 8'h08;
        16'h6042: b = 8'h80;
        16'h6043: b = 8'h00;
        16'h6044: b = 8'h06;
        16'h6045: b = 8'h60;
        16'h6046: b = 8'h00;
        16'h6047: b = 8'h08;
        16'h6048: b = 8'h80;
        16'h6049: b = 8'h00;
        16'h604A: b = 8'h06;
        16'h604B: b = 8'h60;
        16'h604C: b = 8'h00;
        16'h604D: b = 8'h06;
        16'h604E: b = 8'h60;
        // body colors
        16'h6050: b = 8'h00;
        16'h6051: b = 8'hC3;
        16'h6052: b = 8'hE3;
        16'h6053: b = 8'h00;
        16'h6054: b = 8'h1E;
        16'h6055: b = 8'h1E;
        16'h6056: b = 8'h00;
        16'h6057: b = 8'hC3;
        16'h6058: b = 8'hE3;
        16'h6059: b = 8'h00;
        16'h605A: b = 8'hC3;
        16'h605B: b = 8'hE3;
        // stick parameters
        16'h6087: b = 8'h01;
        16'h6088: b = 8'h10;
        16'h6089: b = 8'hAE;
        16'h608B: b = 8'h06;
        16'h608C: b = 8'h60;
        default: ;
      endcase
    end
    return b;
  endfunction

endpackage

// ----- rtl/crr_ctrl.sv -----
// sequencing state machine of the controller report responder
`timescale 1ns / 1ps

module crr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 req_type_i,
  input  logic                 end_of_write_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output crr_pkg::crr_cmd_t    cmd_o,
  input  crr_pkg::crr_status_t status_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIN,
    ST_COPY,
    ST_STREAM
  } state_e;

  state_e state_q;
  logic   in_fire;
  logic   out_fire;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_STREAM);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  // commands to the datapath
  always_comb begin
    cmd_o            = '0;
    cmd_o.clear_step = (state_q == ST_CLEAR);
    cmd_o.wr_byte    = in_fire && !req_type_i;
    cmd_o.rd_start   = in_fire && req_type_i;
    cmd_o.finish     = (state_q == ST_FIN);
    cmd_o.copy_step  = (state_q == ST_COPY);
    cmd_o.rd_next    = out_fire && !status_i.stream_final;
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          if (status_i.clear_done) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_fire) begin
            if (req_type_i) state_q <= ST_STREAM;
            else if (end_of_write_i) state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          state_q <= status_i.copy_needed ? ST_COPY : ST_IDLE;
        end
        ST_COPY: begin
          if (status_i.copy_done) state_q <= ST_IDLE;
        end
        ST_STREAM: begin
          if (out_fire && status_i.stream_final) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/crr_datapath.sv -----
// registers, flash memory and reply generation of the controller report responder
`timescale 1ns / 1ps

module crr_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  crr_pkg::crr_cmd_t    cmd_i,
  output crr_pkg::crr_status_t status_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [6:0]           cfg_data_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 end_of_write_i,
  input  logic [6:0]           read_limit_i,
  output logic [7:0]           report_byte_o,
  output logic [5:0]           byte_position_o,
  output logic                 has_data_o,
  output logic                 final_byte_o
);

  localparam int AW = crr_pkg::FLASH_AW;

  typedef enum logic {RT_ACK, RT_INPUT} rtype_e;

  // configuration
  logic [1:0] kind_q;
  logic [6:0] batt_q;
  logic [2:0] devnum_q;

  // report parsing state
  logic [7:0]  mode_q, counter_q, sub_q, req_q, marg_q;
  logic [6:0]  wpos_q, lastpos_q;
  logic [31:0] offset_q;
  logic        lead_q;
  logic [5:0]  reply_len_q;

  // flash memory and sweep / copy counters
  logic [7:0]                  flash_mem [crr_pkg::FLASH_BYTES];
  logic [AW-1:0]               clr_q;
  logic [4:0]                  issue_q;
  logic                        rv_q;
  logic [crr_pkg::DATA_AW-1:0] widx_q;
  logic [7:0]                  fr_data_q;

  // reply snapshot
  rtype_e     rtype_q;
  logic [7:0] hdr_q, rcnt_q, rbat_q, ack_q, rsub_q;
  logic [7:0] body_q [crr_pkg::BODY_DEPTH];
  logic [7:0] data_q [crr_pkg::DATA_DEPTH];
  logic [4:0] dn_q;

  // stream
  logic [5:0] sidx_q, sn_q;

  // write-byte flash store decision
  logic [6:0]    wrel;
  logic          fw_hit;
  logic          fw_en;
  logic [AW-1:0] fw_addr;
  logic [7:0]    fw_data;
  assign wrel   = wpos_q - 7'd16;
  assign fw_hit = cmd_i.wr_byte && (wpos_q >= 7'd16) && (wpos_q < 7'd127) && lead_q &&
                  (sub_q == crr_pkg::SUB_FLASH_WR) && ({1'b0, wrel} < req_q) &&
                  (({1'b0, offset_q} + 33'(wrel)) < 33'(crr_pkg::FLASH_BYTES));

  always_comb begin
    if (cmd_i.clear_step) begin
      fw_en   = 1'b1;
      fw_addr = clr_q;
      fw_data = crr_pkg::factory_byte(24'(clr_q));
    end else begin
      fw_en   = fw_hit;
      fw_addr = offset_q[AW-1:0] + AW'(wrel);
      fw_data = data_byte_i;
    end
  end

  // finish decisions
  logic       fin_ok, fin_rd;
  logic [7:0] fin_m;
  logic [31:0] room;
  logic [4:0] fin_n;
  logic [7:0] fin_ack;
  logic [15:0] volts;
  assign fin_ok = lead_q && (lastpos_q >= 7'd10);
  assign fin_rd = (sub_q == crr_pkg::SUB_FLASH_RD) && (lastpos_q >= 7'd15);
  assign fin_m  = (req_q < 8'(crr_pkg::MAX_READ_CHUNK)) ? req_q : 8'(crr_pkg::MAX_READ_CHUNK);
  assign room   = 32'(crr_pkg::FLASH_BYTES) - offset_q;
  assign volts  = crr_pkg::level_volts(batt_q);

  always_comb begin
    if (offset_q >= 32'(crr_pkg::FLASH_BYTES)) fin_n = 5'd0;
    else if (room < 32'(fin_m)) fin_n = room[4:0];
    else fin_n = fin_m[4:0];
    case (sub_q)
      crr_pkg::SUB_DEV_INFO: fin_ack = crr_pkg::ACK_DEV;
      crr_pkg::SUB_FLASH_RD: fin_ack = crr_pkg::ACK_FLASH;
      crr_pkg::SUB_MODE_QRY: fin_ack = crr_pkg::ACK_QUERY;
      crr_pkg::SUB_BATTERY:  fin_ack = crr_pkg::ACK_BATT;
      default:               fin_ack = crr_pkg::ACK_PLAIN;
    endcase
  end

  // input report build decisions
  logic       build;
  logic [7:0] cnt1;
  logic [1:0] step;
  logic [7:0] sbit, in_b3, in_b5;
  logic [5:0] len_eff, rd_n;
  assign build = (reply_len_q == 6'd0) && (mode_q[7:4] == 4'h3);
  assign cnt1  = counter_q + 8'd1;
  assign step  = cnt1[4:3];
  assign sbit  = (step == 2'd0) ? 8'h00 : 8'(8'h01 << (step - 2'd1));
  assign len_eff = build ? 6'(crr_pkg::REPLY_LEN) : reply_len_q;
  assign rd_n    = (read_limit_i < {1'b0, len_eff}) ? read_limit_i[5:0] : len_eff;

  always_comb begin
    in_b3 = 8'h00;
    in_b5 = 8'h00;
    case (kind_q)
      2'd0: in_b5 = (step == 2'd0) ? 8'h42 : sbit;
      2'd1: in_b3 = (step == 2'd0) ? 8'h08 : sbit;
      default: begin
        in_b3 = (step == 2'd0) ? 8'h08 : 8'h00;
        in_b5 = (step == 2'd0) ? 8'h02 : sbit;
      end
    endcase
  end

  // control and parsing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= 2'd0;
      batt_q      <= 7'd100;
      devnum_q    <= 3'd1;
      mode_q      <= 8'd0;
      counter_q   <= 8'd0;
      sub_q       <= 8'd0;
      req_q       <= 8'd0;
      marg_q      <= 8'd0;
      wpos_q      <= 7'd0;
      offset_q    <= 32'd0;
      lead_q      <= 1'b0;
      reply_len_q <= 6'd0;
      clr_q       <= '0;
      issue_q     <= 5'd0;
      rv_q        <= 1'b0;
      sidx_q      <= 6'd0;
      sn_q        <= 6'd0;
    end else begin
      // configuration write
      if (cfg_we_i) begin
        case (cfg_index_i)
          crr_pkg::CFG_DEVICE_KIND:   kind_q   <= cfg_data_i[1:0];
          crr_pkg::CFG_BATTERY_LEVEL: batt_q   <= cfg_data_i;
          crr_pkg::CFG_DEVICE_NUMBER: devnum_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      // output report byte
      if (cmd_i.wr_byte) begin
        if (wpos_q < 7'd127) begin
          if (wpos_q == 7'd0) lead_q <= (data_byte_i == crr_pkg::LEAD_OUT_REPORT);
          if (wpos_q == 7'd10) sub_q <= data_byte_i;
          if (wpos_q == 7'd11) begin
            offset_q[7:0] <= data_byte_i;
            marg_q        <= data_byte_i;
          end
          if (wpos_q == 7'd12) offset_q[15:8]  <= data_byte_i;
          if (wpos_q == 7'd13) offset_q[23:16] <= data_byte_i;
          if (wpos_q == 7'd14) offset_q[31:24] <= data_byte_i;
          if (wpos_q == 7'd15) req_q <= data_byte_i;
          wpos_q <= wpos_q + 7'd1;
        end
        if (end_of_write_i) wpos_q <= 7'd0;
      end
      // report finish
      if (cmd_i.finish) begin
        issue_q <= 5'd0;
        rv_q    <= 1'b0;
        if (!fin_ok) begin
          reply_len_q <= 6'd0;
        end else begin
          counter_q   <= counter_q + 8'd1;
          reply_len_q <= fin_rd ? 6'(crr_pkg::DATA_FIRST) + 6'(fin_n)
                                : 6'(crr_pkg::REPLY_LEN);
          if ((sub_q == crr_pkg::SUB_SET_MODE) && (lastpos_q >= 7'd11)) mode_q <= marg_q;
        end
      end
      // flash copy issue
      if (cmd_i.copy_step) begin
        if (issue_q < dn_q) begin
          issue_q <= issue_q + 5'd1;
          rv_q    <= 1'b1;
        end else begin
          rv_q <= 1'b0;
        end
      end
      // read request
      if (cmd_i.rd_start) begin
        if (build) counter_q <= cnt1;
        reply_len_q <= 6'd0;
        sidx_q      <= 6'd0;
        sn_q        <= rd_n;
      end
      if (cmd_i.rd_next) sidx_q <= sidx_q + 6'd1;
      // clearing sweep
      if (cmd_i.clear_step) clr_q <= clr_q + AW'(1);
    end
  end

  // reply snapshot and flash data
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_byte && end_of_write_i) lastpos_q <= wpos_q;
    if (cmd_i.copy_step && (issue_q < dn_q)) widx_q <= issue_q;
    if (cmd_i.copy_step && rv_q) data_q[widx_q] <= fr_data_q;
    if (cmd_i.finish && fin_ok) begin
      rtype_q <= RT_ACK;
      hdr_q   <= crr_pkg::HDR_REPLY;
      rcnt_q  <= counter_q;
      rbat_q  <= {crr_pkg::level_nibble(batt_q), 4'h6};
      ack_q   <= fin_ack;
      rsub_q  <= sub_q;
      dn_q    <= 5'd0;
      for (int k = 0; k < crr_pkg::BODY_DEPTH; k++) body_q[k] <= 8'h00;
      case (sub_q)
        crr_pkg::SUB_DEV_INFO: begin
          body_q[0] <= 8'h04;
          body_q[1] <= 8'h21;
          body_q[2] <= (kind_q == 2'd0) ? 8'h01 : ((kind_q == 2'd1) ? 8'h02 : 8'h03);
          body_q[3] <= 8'h02;
          body_q[4] <= 8'h02;
          data_q[0] <= 8'h00;
          data_q[1] <= 8'h00;
          data_q[2] <= 8'h00;
          data_q[3] <= 8'h10;
          data_q[4] <= 8'(devnum_q);
          dn_q      <= 5'd5;
        end
        crr_pkg::SUB_FLASH_RD: begin
          if (fin_rd) begin
            body_q[0] <= offset_q[7:0];
            body_q[1] <= offset_q[15:8];
            body_q[2] <= offset_q[23:16];
            body_q[3] <= offset_q[31:24];
            body_q[4] <= 8'(fin_n);
            dn_q      <= fin_n;
          end
        end
        crr_pkg::SUB_MODE_QRY: begin
          if ((lastpos_q >= 7'd12) && (marg_q == crr_pkg::QRY_MATCH)) body_q[2] <= 8'h10;
        end
        crr_pkg::SUB_BATTERY: begin
          body_q[0] <= volts[7:0];
          body_q[1] <= volts[15:8];
        end
        default: ;
      endcase
    end
    if (cmd_i.rd_start && build) begin
      rtype_q   <= RT_INPUT;
      hdr_q     <= mode_q;
      rcnt_q    <= counter_q;
      rbat_q    <= {crr_pkg::level_nibble(batt_q), 4'h6};
      body_q[0] <= in_b3;
      body_q[1] <= in_b5;
    end
  end

  // flash memory ports
  always_ff @(posedge clk_i) begin
    if (fw_en) flash_mem[fw_addr] <= fw_data;
    if (cmd_i.copy_step && (issue_q < dn_q)) begin
      fr_data_q <= flash_mem[offset_q[AW-1:0] + AW'(issue_q)];
    end
  end

  // reply byte at the stream position
  logic [crr_pkg::DATA_AW-1:0] didx;
  logic [7:0]                  sbyte;
  assign didx = crr_pkg::DATA_AW'(sidx_q - 6'(crr_pkg::DATA_FIRST));

  always_comb begin
    sbyte = 8'h00;
    case (sidx_q)
      6'd0:  sbyte = hdr_q;
      6'd1:  sbyte = rcnt_q;
      6'd2:  sbyte = rbat_q;
      6'd7:  sbyte = 8'h08;
      6'd8:  sbyte = 8'h80;
      6'd10: sbyte = 8'h08;
      6'd11: sbyte = 8'h80;
      default: ;
    endcase
    if (rtype_q == RT_INPUT) begin
      if (sidx_q == 6'd3) sbyte = body_q[0];
      if (sidx_q == 6'd5) sbyte = body_q[1];
      if (sidx_q == 6'd18) sbyte = 8'h40;
    end else begin
      if (sidx_q == 6'd13) sbyte = ack_q;
      if (sidx_q == 6'd14) sbyte = rsub_q;
      if (sidx_q >= 6'd15 && sidx_q < 6'(crr_pkg::DATA_FIRST)) begin
        sbyte = body_q[3'(sidx_q - 6'd15)];
      end
      if (sidx_q >= 6'(crr_pkg::DATA_FIRST) && (5'(didx) < dn_q)) sbyte = data_q[didx];
    end
  end

  // result fields
  assign has_data_o      = (sn_q != 6'd0);
  assign report_byte_o   = has_data_o ? sbyte : 8'h00;
  assign byte_position_o = has_data_o ? sidx_q : 6'd0;
  assign final_byte_o    = status_o.stream_final;

  // status to the controller
  assign status_o.clear_done   = (clr_q == AW'(crr_pkg::FLASH_BYTES - 1));
  assign status_o.copy_needed  = fin_ok && fin_rd && (fin_n != 5'd0);
  assign status_o.copy_done    = (issue_q == dn_q) && !rv_q;
  assign status_o.stream_final = (sn_q == 6'd0) || ((sidx_q + 6'd1) == sn_q);

endmodule

// ----- rtl/controller_report_responder_unit.sv -----
// top level of the controller report responder
//
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------------------
//  input    | in_valid_i / in_ready_o  | req_type_i data_byte_i end_of_write_i read_limit_i
//  output   | out_valid_o / out_ready_i| report_byte_o byte_position_o has_data_o final_byte_o
//  config   | cfg_we_i                 | cfg_index_i cfg_data_i
//
// after reset a clearing pass writes the factory image into all FLASH_BYTES (524288) flash
// bytes, one byte a cycle; no transaction is taken until it ends.
// report bytes are taken while the input is idle; the last byte adds a finish state, and
// a flash read subcommand then adds a copy state moving n flash bytes through the read port.
// a read request starts the stream, then one result per cycle while out_ready_i is high;
// the input side stays stalled until the last result is taken.
`timescale 1ns / 1ps

module controller_report_responder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [6:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       req_type_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_write_i,
  input  logic [6:0] read_limit_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] report_byte_o,
  output logic [5:0] byte_position_o,
  output logic       has_data_o,
  output logic       final_byte_o
);

  crr_pkg::crr_cmd_t    cmd;
  crr_pkg::crr_status_t status;

  // sequencing
  crr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .end_of_write_i (end_of_write_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cmd_o          (cmd),
    .status_i       (status)
  );

  // state, flash and reply generation
  crr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .data_byte_i     (data_byte_i),
    .end_of_write_i  (end_of_write_i),
    .read_limit_i    (read_limit_i),
    .report_byte_o   (report_byte_o),
    .byte_position_o (byte_position_o),
    .has_data_o      (has_data_o),
    .final_byte_o    (final_byte_o)
  );

endmodule
